>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the dual-seed hash block.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies another one on the following edge.
`define ASSERT_NEXT(label, cond, expr, msg) \
  `ASSERT_CLKD(label, (cond) |=> (expr), msg)

`endif

>>> rtl/dsx_pkg.sv
// Package of the dual-seed XXH32 hash block: constants, beat and result types,
// back-end state encoding and the rotate helper. Depends on nothing.
`default_nettype none

package dsx_pkg;

  localparam logic [31:0] PRIME_A = 32'd2654435761;
  localparam logic [31:0] PRIME_B = 32'd2246822519;
  localparam logic [31:0] PRIME_C = 32'd3266489917;
  localparam logic [31:0] PRIME_D = 32'd668265263;
  localparam logic [31:0] PRIME_E = 32'd374761393;

  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam logic CFG_SEED_FIRST  = 1'b0;
  localparam logic CFG_SEED_SECOND = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [31:0] hash_second;
    logic [31:0] hash_first;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FOLD_V,
    ST_FOLD_L,
    ST_FIN_INIT,
    ST_FIN_CHK,
    ST_WORD_M,
    ST_WORD_H,
    ST_BYTE_M,
    ST_BYTE_H,
    ST_AV1,
    ST_AV2,
    ST_AV3,
    ST_OUT
  } core_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

`default_nettype wire

>>> rtl/dual_seed_xxh32_hash.sv
// Dual-seed XXH32 hasher. Each FIFO byte goes into the stripe buffer; the 16th
// byte of a stripe starts lane folding, a multiply and a lane update per lane.
// Per hash the last byte starts init and check steps, a multiply and a hash
// step per leftover word or byte, the avalanche and the output register load.
// Input beats queue in a FIFO meanwhile. Synchronous active-low reset clears
// the seeds, counters, queue and valid flags; no clearing pass is needed.
`default_nettype none

module dual_seed_xxh32_hash import dsx_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [31:0] hash_first, [63:32] hash_second
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  `include "assert_macros.svh"

  logic [31:0] seed_first_r, seed_second_r;
  logic        q_valid, q_pop;
  beat_t       q_beat;
  logic        res_valid, res_ready;
  result_t     res;
  logic        out_valid_r;
  logic [63:0] out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_first_r  <= '0;
      seed_second_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEED_FIRST:  seed_first_r  <= cfg_data;
        CFG_SEED_SECOND: seed_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dsx_rx #(.FIFO_DEPTH(FIFO_DEPTH)) u_rx (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_beat    (q_beat),
    .q_pop     (q_pop)
  );

  dsx_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .seed_first  (seed_first_r),
    .seed_second (seed_second_r),
    .q_valid     (q_valid),
    .q_beat      (q_beat),
    .q_pop       (q_pop),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= {res.hash_second, res.hash_first};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A result offered by the back end stays put until the output register takes it.
  `ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res),
               "back-end result changed while stalled")
  // The output register only fills from an offered result.
  `ASSERT_NEXT(a_out_src, !out_valid_r && !res_valid, !out_valid_r,
               "output beat appeared without a result")

endmodule

`default_nettype wire

>>> rtl/dsx_rx.sv
// Front end of the dual-seed hash block: takes byte beats and queues them
// for the back end in a small FIFO. Depends on dsx_pkg.
`default_nettype none

module dsx_rx import dsx_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  output logic            q_valid,
  output beat_t           q_beat,
  input  wire logic       q_pop
);

  localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

  beat_t          mem_r [FIFO_DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           push, pop;

  assign in_tready = (cnt_r != FULL_CNT);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_beat    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data: in_tdata, last: in_tlast};
    end
  end

endmodule

`default_nettype wire

>>> rtl/dsx_core.sv
// Back end of the dual-seed hash block: stripe buffer, lane folding and the
// finish sequence, all on one shared 32x32 multiplier. Depends on dsx_pkg.
`default_nettype none

module dsx_core import dsx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] seed_first,
  input  wire logic [31:0] seed_second,
  input  wire logic        q_valid,
  input  wire beat_t       q_beat,
  output logic             q_pop,
  output logic             res_valid,
  output result_t          res,
  input  wire logic        res_ready
);

  core_state_t  state_r, state_nxt;
  logic [31:0]  buf_r [4];
  logic [31:0]  lanes_r [2][4];
  logic [31:0]  lanes_nxt [2][4];
  logic [31:0]  count_r, count_nxt;
  logic         sd_r, sd_nxt;
  logic         last_r, last_nxt;
  logic [3:0]   tail_r, tail_nxt;
  logic [3:0]   pos_r, pos_nxt;
  logic [2:0]   k_r, k_nxt;
  logic         sel_r, sel_nxt;
  logic [31:0]  h_r, h_nxt;
  logic [31:0]  prod_r, prod_nxt;
  logic [31:0]  res_r [2];
  logic [31:0]  res_nxt [2];
  logic [31:0]  mul_a, mul_b, mul_p;
  logic [1:0]   wsel;
  logic [31:0]  word;
  logic [7:0]   byte_v;
  logic [31:0]  lane_k, seed_sel, base;
  logic [3:0]   pos_in;
  logic         pop;
  logic         word_left, byte_left;

  assign pos_in    = count_r[3:0];
  assign pop       = q_pop;
  assign wsel      = (state_r == ST_FOLD_V) ? k_r[1:0] : pos_r[3:2];
  assign word      = buf_r[wsel];
  assign byte_v    = word[8*pos_r[1:0] +: 8];
  assign lane_k    = lanes_r[k_r[2]][k_r[1:0]];
  assign seed_sel  = sel_r ? seed_second : seed_first;
  assign word_left = ({1'b0, pos_r} + 5'd4) <= {1'b0, tail_r};
  assign byte_left = pos_r < tail_r;
  assign mul_p     = mul_a * mul_b;
  assign res       = '{hash_second: res_r[1], hash_first: res_r[0]};

  always_comb begin
    base = sd_r ? (rotl(lanes_r[sel_r][0], 1) + rotl(lanes_r[sel_r][1], 7)
                 + rotl(lanes_r[sel_r][2], 12) + rotl(lanes_r[sel_r][3], 18))
                : (seed_sel + PRIME_E);
  end

  // Multiplier operand selection; each step registers its product.
  always_comb begin
    case (state_r)
      ST_FOLD_V: begin mul_a = word;                        mul_b = PRIME_B; end
      ST_FOLD_L: begin mul_a = rotl(lane_k + prod_r, 13);   mul_b = PRIME_A; end
      ST_WORD_M: begin mul_a = word;                        mul_b = PRIME_C; end
      ST_WORD_H: begin mul_a = rotl(h_r + prod_r, 17);      mul_b = PRIME_D; end
      ST_BYTE_M: begin mul_a = {24'd0, byte_v};             mul_b = PRIME_E; end
      ST_BYTE_H: begin mul_a = rotl(h_r + prod_r, 11);      mul_b = PRIME_A; end
      ST_AV1:    begin mul_a = h_r ^ (h_r >> 15);           mul_b = PRIME_B; end
      ST_AV2:    begin mul_a = h_r ^ (h_r >> 13);           mul_b = PRIME_C; end
      default:   begin mul_a = '0;                          mul_b = '0;      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (pos_in == 4'd15)   state_nxt = ST_FOLD_V;
          else if (q_beat.last)  state_nxt = ST_FIN_INIT;
        end
      end
      ST_FOLD_V:   state_nxt = ST_FOLD_L;
      ST_FOLD_L: begin
        if (k_r != 3'd7)  state_nxt = ST_FOLD_V;
        else if (last_r)  state_nxt = ST_FIN_INIT;
        else              state_nxt = ST_IDLE;
      end
      ST_FIN_INIT: state_nxt = ST_FIN_CHK;
      ST_FIN_CHK: begin
        if (word_left)       state_nxt = ST_WORD_M;
        else if (byte_left)  state_nxt = ST_BYTE_M;
        else                 state_nxt = ST_AV1;
      end
      ST_WORD_M:   state_nxt = ST_WORD_H;
      ST_WORD_H:   state_nxt = ST_FIN_CHK;
      ST_BYTE_M:   state_nxt = ST_BYTE_H;
      ST_BYTE_H:   state_nxt = ST_FIN_CHK;
      ST_AV1:      state_nxt = ST_AV2;
      ST_AV2:      state_nxt = ST_AV3;
      ST_AV3:      state_nxt = sel_r ? ST_OUT : ST_FIN_INIT;
      ST_OUT: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    q_pop     = (state_r == ST_IDLE) && q_valid;
    res_valid = (state_r == ST_OUT);
  end

  // Datapath updates.
  always_comb begin
    lanes_nxt = lanes_r;
    count_nxt = count_r;
    sd_nxt    = sd_r;
    last_nxt  = last_r;
    tail_nxt  = tail_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    sel_nxt   = sel_r;
    h_nxt     = h_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          // Lanes take the seeds at the first byte of a message.
          if (count_r == '0 && !sd_r) begin
            lanes_nxt[0][0] = seed_first + PRIME_A + PRIME_B;
            lanes_nxt[0][1] = seed_first + PRIME_B;
            lanes_nxt[0][2] = seed_first;
            lanes_nxt[0][3] = seed_first - PRIME_A;
            lanes_nxt[1][0] = seed_second + PRIME_A + PRIME_B;
            lanes_nxt[1][1] = seed_second + PRIME_B;
            lanes_nxt[1][2] = seed_second;
            lanes_nxt[1][3] = seed_second - PRIME_A;
          end
          count_nxt = count_r + 32'd1;
          last_nxt  = q_beat.last;
          sel_nxt   = 1'b0;
          k_nxt     = '0;
          if (pos_in == 4'd15) begin
            sd_nxt   = 1'b1;
            tail_nxt = '0;
          end else begin
            tail_nxt = pos_in + 4'd1;
          end
        end
      end
      ST_FOLD_V: prod_nxt = mul_p;
      ST_FOLD_L: begin
        lanes_nxt[k_r[2]][k_r[1:0]] = mul_p;
        k_nxt = k_r + 3'd1;
      end
      ST_FIN_INIT: begin
        h_nxt   = base + count_r;
        pos_nxt = '0;
      end
      ST_WORD_M: prod_nxt = mul_p;
      ST_WORD_H: begin
        h_nxt   = mul_p;
        pos_nxt = pos_r + 4'd4;
      end
      ST_BYTE_M: prod_nxt = mul_p;
      ST_BYTE_H: begin
        h_nxt   = mul_p;
        pos_nxt = pos_r + 4'd1;
      end
      ST_AV1: h_nxt = mul_p;
      ST_AV2: h_nxt = mul_p;
      ST_AV3: begin
        res_nxt[sel_r] = h_r ^ (h_r >> 16);
        sel_nxt = 1'b1;
      end
      ST_OUT: begin
        if (res_ready) begin
          count_nxt = '0;
          sd_nxt    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      sd_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sd_r    <= sd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
    last_r  <= last_nxt;
    tail_r  <= tail_nxt;
    pos_r   <= pos_nxt;
    k_r     <= k_nxt;
    sel_r   <= sel_nxt;
    h_r     <= h_nxt;
    prod_r  <= prod_nxt;
    res_r   <= res_nxt;
  end

  // Stripe buffer, written one byte lane at a time.
  always_ff @(posedge clk) begin
    if (pop) begin
      buf_r[pos_in[3:2]][8*pos_in[1:0] +: 8] <= q_beat.data;
    end
  end

endmodule

`default_nettype wire
